// ===== hw/rtl/bdq_pkg.sv =====
// Package for the bounded double-ended queue: sizes, operation and status codes,
// per-cell control types and the sequencer state type. No dependencies.
package bdq_pkg;

   localparam int DEPTH  = 32;
   localparam int DATA_W = 32;
   localparam int MODE_W = 3;
   localparam int STAT_W = 2;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = $clog2(DEPTH);

   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DUMP       = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_FRONT,
      CELL_PUSH_BACK,
      CELL_POP_FRONT,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [CNT_W-1:0] count;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

endpackage

// ===== hw/rtl/bdq_if.sv =====
// Valid/ready channel interfaces for the queue's request and response words.
// Depends on bdq_pkg.
interface bdq_req_if;
   logic                                    valid;
   logic                                    ready;
   logic        [bdq_pkg::MODE_W-1:0]       mode;
   logic signed [bdq_pkg::DATA_W-1:0]       data_in;

   modport source (output valid, output mode, output data_in, input ready);
   modport sink   (input valid, input mode, input data_in, output ready);
endinterface

interface bdq_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [bdq_pkg::DATA_W-1:0]       data_out;
   logic        [bdq_pkg::STAT_W-1:0]       status;
   logic                                    last;

   modport source (output valid, output data_out, output status, output last, input ready);
   modport sink   (input valid, input data_out, input status, input last, output ready);
endinterface

// ===== hw/rtl/bounded_double_ended_queue_core.sv =====
// Top level of the bounded double-ended queue: a chain of storage cells with
// front at cell 0, a word sequencer and a registered response stage.
// Depends on bdq_pkg, bdq_req_if, bdq_rsp_if and bdq_cell.
//
// Usage:
//   req_port carries one word per operation: mode (push front, push back,
//   pop front, pop back, dump) and data_in. rsp_port returns data_out,
//   status (ok, empty, full) and last, which marks the final response word
//   of a request.
//   Push and pop words get a registered response that appears in the cycle
//   after acceptance, and a new request is taken every cycle while the
//   response side keeps up. A dump of N elements holds the request side
//   until its last word is registered and returns N words, front to back, by
//   rotating the cell chain one position per word; the queue is unchanged
//   afterwards. Undefined modes are consumed with no response.
//   Reset empties the queue and drops any pending response; no clearing pass
//   is needed. When the receiver stalls, the response word holds and the
//   request side waits until the response register is free or being taken.
module bounded_double_ended_queue_core (
   input  logic         clock,
   input  logic         reset,
   bdq_req_if.sink      req_port,
   bdq_rsp_if.source    rsp_port
);

   logic signed [bdq_pkg::DATA_W-1:0] cell_data [bdq_pkg::DEPTH];

   bdq_pkg::state_type                 state_ff, state_in;
   logic        [bdq_pkg::CNT_W-1:0]   count_ff, count_in;
   logic        [bdq_pkg::CNT_W-1:0]   remain_ff, remain_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [bdq_pkg::DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic        [bdq_pkg::STAT_W-1:0]  rsp_stat_ff, rsp_stat_in;
   logic                               rsp_last_ff, rsp_last_in;

   bdq_pkg::cell_ctrl_type             cell_ctrl;
   logic                               out_free;
   logic                               req_accept;
   logic        [bdq_pkg::CNT_W-1:0]   count_minus;
   logic        [bdq_pkg::IDX_W-1:0]   tail_idx;

   assign out_free       = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = (state_ff == bdq_pkg::ST_IDLE) && out_free;
   assign req_accept     = req_port.valid && req_port.ready;
   assign count_minus    = count_ff - bdq_pkg::CNT_W'(1);
   assign tail_idx       = count_minus[bdq_pkg::IDX_W-1:0];

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      remain_in      = remain_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_port.ready;
      rsp_data_in    = rsp_data_ff;
      rsp_stat_in    = rsp_stat_ff;
      rsp_last_in    = rsp_last_ff;
      cell_ctrl.op    = bdq_pkg::CELL_HOLD;
      cell_ctrl.count = count_ff;

      if (req_accept) begin
         case (req_port.mode)
            bdq_pkg::MODE_PUSH_FRONT, bdq_pkg::MODE_PUSH_BACK: begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_last_in  = 1'b1;
               if (count_ff == bdq_pkg::CNT_W'(bdq_pkg::DEPTH)) begin
                  rsp_stat_in = bdq_pkg::STAT_FULL;
               end else begin
                  rsp_stat_in  = bdq_pkg::STAT_OK;
                  count_in     = count_ff + bdq_pkg::CNT_W'(1);
                  cell_ctrl.op = (req_port.mode == bdq_pkg::MODE_PUSH_FRONT) ?
                                 bdq_pkg::CELL_PUSH_FRONT : bdq_pkg::CELL_PUSH_BACK;
               end
            end
            bdq_pkg::MODE_POP_FRONT, bdq_pkg::MODE_POP_BACK: begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (count_ff == '0) begin
                  rsp_stat_in = bdq_pkg::STAT_EMPTY;
                  rsp_data_in = '0;
               end else begin
                  rsp_stat_in = bdq_pkg::STAT_OK;
                  count_in    = count_minus;
                  if (req_port.mode == bdq_pkg::MODE_POP_FRONT) begin
                     rsp_data_in  = cell_data[0];
                     cell_ctrl.op = bdq_pkg::CELL_POP_FRONT;
                  end else begin
                     rsp_data_in  = cell_data[tail_idx];
                  end
               end
            end
            bdq_pkg::MODE_DUMP: begin
               if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_stat_in  = bdq_pkg::STAT_EMPTY;
                  rsp_last_in  = 1'b1;
               end else begin
                  state_in  = bdq_pkg::ST_DUMP;
                  remain_in = count_ff;
               end
            end
            default: ;
         endcase
      end else if (state_ff == bdq_pkg::ST_DUMP && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = cell_data[0];
         rsp_stat_in  = bdq_pkg::STAT_OK;
         rsp_last_in  = (remain_ff == bdq_pkg::CNT_W'(1));
         cell_ctrl.op = bdq_pkg::CELL_ROTATE;
         remain_in    = remain_ff - bdq_pkg::CNT_W'(1);
         if (remain_ff == bdq_pkg::CNT_W'(1)) state_in = bdq_pkg::ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdq_pkg::ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_last_ff <= rsp_last_in;
   end

   for (genvar i = 0; i < bdq_pkg::DEPTH; i++) begin : g_cell
      logic signed [bdq_pkg::DATA_W-1:0] prev_word;
      logic signed [bdq_pkg::DATA_W-1:0] next_word;

      if (i == 0) begin : g_first
         assign prev_word = req_port.data_in;
      end else begin : g_mid
         assign prev_word = cell_data[i-1];
      end

      if (i == bdq_pkg::DEPTH - 1) begin : g_end
         assign next_word = cell_data[i];
      end else begin : g_inner
         assign next_word = cell_data[i+1];
      end

      bdq_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .cell_index (bdq_pkg::IDX_W'(i)),
         .prev_data  (prev_word),
         .next_data  (next_word),
         .push_data  (req_port.data_in),
         .head_data  (cell_data[0]),
         .data_out   (cell_data[i])
      );
   end

   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.data_out = rsp_data_ff;
   assign rsp_port.status   = rsp_stat_ff;
   assign rsp_port.last     = rsp_last_ff;

endmodule

// ===== hw/rtl/bdq_cell.sv =====
// One storage cell of the queue chain; holds the element at its position.
// Depends on bdq_pkg.
module bdq_cell (
   input  logic                               clock,
   input  bdq_pkg::cell_ctrl_type             ctrl,
   input  logic        [bdq_pkg::IDX_W-1:0]   cell_index,
   input  logic signed [bdq_pkg::DATA_W-1:0]  prev_data,
   input  logic signed [bdq_pkg::DATA_W-1:0]  next_data,
   input  logic signed [bdq_pkg::DATA_W-1:0]  push_data,
   input  logic signed [bdq_pkg::DATA_W-1:0]  head_data,
   output logic signed [bdq_pkg::DATA_W-1:0]  data_out
);

   logic signed [bdq_pkg::DATA_W-1:0] cell_data_ff;
   logic signed [bdq_pkg::DATA_W-1:0] cell_data_in;
   logic        [bdq_pkg::CNT_W-1:0]  pos_plus_one;

   assign pos_plus_one = bdq_pkg::CNT_W'(cell_index) + bdq_pkg::CNT_W'(1);

   always_comb begin
      cell_data_in = cell_data_ff;
      case (ctrl.op)
         bdq_pkg::CELL_PUSH_FRONT: cell_data_in = prev_data;
         bdq_pkg::CELL_PUSH_BACK: begin
            if (bdq_pkg::CNT_W'(cell_index) == ctrl.count) cell_data_in = push_data;
         end
         bdq_pkg::CELL_POP_FRONT: cell_data_in = next_data;
         bdq_pkg::CELL_ROTATE: begin
            // head wraps to the tail slot, occupied cells below it shift down
            if (pos_plus_one == ctrl.count) cell_data_in = head_data;
            else if (pos_plus_one < ctrl.count) cell_data_in = next_data;
         end
         default: cell_data_in = cell_data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      cell_data_ff <= cell_data_in;
   end

   assign data_out = cell_data_ff;

endmodule

// ===== dv/bounded_double_ended_queue_checker.sv =====
// Checker for the bounded double-ended queue: watches the request and response
// channels, keeps a shadow queue and compares every response word in order.
// Depends on bdq_pkg, bdq_req_if and bdq_rsp_if.
module bounded_double_ended_queue_checker (
   input  logic clock,
   input  logic reset,
   bdq_req_if   req_mon,
   bdq_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_words
);

   typedef struct packed {
      logic signed [bdq_pkg::DATA_W-1:0] data;
      logic        [bdq_pkg::STAT_W-1:0] status;
      logic                              last;
   } rsp_word_type;

   logic signed [bdq_pkg::DATA_W-1:0] shadow_ring [bdq_pkg::DEPTH];
   logic        [bdq_pkg::IDX_W-1:0]  front_slot;
   logic        [bdq_pkg::CNT_W-1:0]  fill_level;
   rsp_word_type                      expected_words [$];
   int                                errors = 0;

   function automatic int slot_of(int offset);
      return (int'(front_slot) + offset) % bdq_pkg::DEPTH;
   endfunction

   // Shadow of one request: updates the queue and queues the words it returns.
   task automatic predict_queue_op(input logic [bdq_pkg::MODE_W-1:0]       mode,
                                   input logic signed [bdq_pkg::DATA_W-1:0] value);
      rsp_word_type w;
      w.data   = '0;
      w.status = bdq_pkg::STAT_OK;
      w.last   = 1'b1;
      case (mode)
         bdq_pkg::MODE_PUSH_FRONT, bdq_pkg::MODE_PUSH_BACK: begin
            if (fill_level >= bdq_pkg::DEPTH) begin
               w.status = bdq_pkg::STAT_FULL;
            end else begin
               if (mode == bdq_pkg::MODE_PUSH_FRONT) begin
                  front_slot = bdq_pkg::IDX_W'((int'(front_slot) + bdq_pkg::DEPTH - 1) %
                                               bdq_pkg::DEPTH);
                  shadow_ring[front_slot] = value;
               end else begin
                  shadow_ring[slot_of(int'(fill_level))] = value;
               end
               fill_level++;
            end
            expected_words.push_back(w);
         end
         bdq_pkg::MODE_POP_FRONT, bdq_pkg::MODE_POP_BACK: begin
            if (fill_level == 0) begin
               w.status = bdq_pkg::STAT_EMPTY;
            end else begin
               if (mode == bdq_pkg::MODE_POP_FRONT) begin
                  w.data     = shadow_ring[front_slot];
                  front_slot = bdq_pkg::IDX_W'((int'(front_slot) + 1) % bdq_pkg::DEPTH);
               end else begin
                  w.data = shadow_ring[slot_of(int'(fill_level) - 1)];
               end
               fill_level--;
            end
            expected_words.push_back(w);
         end
         bdq_pkg::MODE_DUMP: begin
            if (fill_level == 0) begin
               w.status = bdq_pkg::STAT_EMPTY;
               expected_words.push_back(w);
            end else begin
               for (int i = 0; i < int'(fill_level); i++) begin
                  w.data = shadow_ring[slot_of(i)];
                  w.last = (i == int'(fill_level) - 1);
                  expected_words.push_back(w);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_rsp_word();
      rsp_word_type got;
      rsp_word_type want;
      got.data   = rsp_mon.data_out;
      got.status = rsp_mon.status;
      got.last   = rsp_mon.last;
      if (expected_words.size() == 0) begin
         $display("%0t: unexpected word, expected none, got data %0d status %0d last %0b",
                  $time, got.data, got.status, got.last);
         errors++;
      end else begin
         want = expected_words.pop_front();
         if (got !== want) begin
            $display({"%0t: word mismatch, expected data %0d status %0d last %0b,",
                      " got data %0d status %0d last %0b"},
                     $time, want.data, want.status, want.last,
                     got.data, got.status, got.last);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_words.delete();
         front_slot = '0;
         fill_level = '0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready)
            check_rsp_word();
         if (req_mon.valid && req_mon.ready)
            predict_queue_op(req_mon.mode, req_mon.data_in);
      end
      fail_count    <= errors;
      pending_words <= expected_words.size();
   end

endmodule

// ===== dv/bounded_double_ended_queue_core_test.sv =====
// Top of the bounded double-ended queue testbench: clock, reset, request words,
// response back-pressure, watchdog and verdict. Depends on bdq_pkg, the channel
// interfaces, bounded_double_ended_queue_core and the queue checker.
module bounded_double_ended_queue_core_test;
   import bdq_pkg::*;

   localparam int WORD_TARGET  = 330;
   localparam int WAIT_MAX     = 17;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_words;
   int   req_burst = 0;
   int   rsp_burst = 0;
   int   words_sent = 0;
   int   idle_cycles = 0;

   bdq_req_if req_chan ();
   bdq_rsp_if rsp_chan ();

   bounded_double_ended_queue_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_chan),
      .rsp_port (rsp_chan)
   );

   bounded_double_ended_queue_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Random wait per word, with occasional runs of back-to-back words.
   function automatic int draw_wait(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         burst = $urandom_range(4, 30);
         return 0;
      end
      return $urandom_range(0, WAIT_MAX);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return {1'b1, {(DATA_W-1){1'b0}}};
         1:       return {1'b0, {(DATA_W-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [MODE_W-1:0] push_side();
      return $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
   endfunction

   function automatic logic [MODE_W-1:0] pop_side();
      return $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
   endfunction

   function automatic logic [MODE_W-1:0] undefined_mode();
      return MODE_W'($urandom_range(int'(MODE_DUMP) + 1, 2**MODE_W - 1));
   endfunction

   task automatic send_word(input logic [MODE_W-1:0]       mode,
                            input logic signed [DATA_W-1:0] value);
      int gap;
      gap = draw_wait(req_burst);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.mode    <= mode;
      req_chan.data_in <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (mode <= MODE_DUMP)
         words_sent++;
   endtask

   task automatic send_random_op();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 8)
         send_word(push_side(), pick_value());
      else if (pick < 16)
         send_word(pop_side(), pick_value());
      else if (pick < 19)
         send_word(MODE_DUMP, pick_value());
      else
         send_word(undefined_mode(), pick_value());
   endtask

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.mode    = MODE_PUSH_FRONT;
      req_chan.data_in = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue, extremes, every operation, undefined modes
      for (int m = int'(MODE_DUMP) + 1; m < 2**MODE_W; m++)
         send_word(MODE_W'(m), pick_value());
      send_word(MODE_POP_FRONT, '0);
      send_word(MODE_POP_BACK, '0);
      send_word(MODE_DUMP, '0);
      send_word(MODE_PUSH_FRONT, {1'b0, {(DATA_W-1){1'b1}}});
      send_word(MODE_PUSH_BACK, {1'b1, {(DATA_W-1){1'b0}}});
      send_word(MODE_PUSH_FRONT, '1);
      send_word(MODE_PUSH_BACK, '0);
      send_word(MODE_DUMP, '1);
      send_word(MODE_POP_BACK, '1);
      send_word(MODE_POP_FRONT, '0);
      send_word(MODE_DUMP, '0);
      send_word(undefined_mode(), '1);
      send_word(MODE_POP_FRONT, '0);
      send_word(MODE_POP_BACK, '0);
      send_word(MODE_POP_BACK, '0);

      // fill past full, dump the full queue, drain past empty
      repeat (DEPTH + 2) send_word(push_side(), pick_value());
      send_word(MODE_DUMP, pick_value());
      repeat (DEPTH + 2) send_word(pop_side(), pick_value());

      while (words_sent < WORD_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1: repeat ($urandom_range(1, DEPTH + 4)) send_word(push_side(), pick_value());
            2, 3: repeat ($urandom_range(1, DEPTH + 4)) send_word(pop_side(), pick_value());
            4: begin
               send_word(MODE_DUMP, pick_value());
               send_random_op();
            end
            9: begin
               send_word(undefined_mode(), pick_value());
               send_random_op();
            end
            default: repeat ($urandom_range(4, 16)) send_random_op();
         endcase
      end
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      forever begin
         stall = draw_wait(rsp_burst);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   // stop a hung run: too many cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== bounded_double_ended_queue_core.f =====
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_if.sv
hw/rtl/bdq_cell.sv
hw/rtl/bounded_double_ended_queue_core.sv
dv/bounded_double_ended_queue_checker.sv
dv/bounded_double_ended_queue_core_test.sv
